@@ src/i2c_sensor_bus_master_top_defines.svh @@
// Assertion macros shared by the I2C sensor bus master modules.
// Depends on a clk and an rst signal in the scope that uses them.
`ifndef I2C_SENSOR_BUS_MASTER_TOP_DEFINES_SVH
`define I2C_SENSOR_BUS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CSM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2csm check failed");

// Next-cycle implication, checked outside reset.
`define I2CSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2csm check failed");

`endif

@@ src/i2csm_pkg.sv @@
// Types, codes and constants for the I2C sensor bus master.
// Used by the front queue, the bus engine and the top level.
package i2csm_pkg;

  localparam int READ_BYTES = 5;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;
  localparam logic [2:0] CMD_SENSOR_READ = 3'd6;
  localparam logic [2:0] CMD_SENSOR_CMD  = 3'd5;
  localparam logic [2:0] CMD_RESERVED    = 3'd7;

  localparam logic [3:0] SEQ_ERR_STOP = 4'd14;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WB_SET, PH_WB_HIGH,
    PH_WB_LOW, PH_WB_TAIL, PH_AK_LOW, PH_AK_POLL, PH_RB_LOW, PH_RB_HIGH,
    PH_RA_LOW, PH_RA_HIGH
  } phase_t;

  typedef enum logic [2:0] {
    EL_START, EL_WRITE, EL_ACK, EL_READ, EL_STOP, EL_END
  } elem_t;

  typedef struct packed {
    logic       start_req;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic [7:0] tx_second_byte;
    logic       ack_after_read;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [7:0]  ack_timeout_limit;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic [31:0] measurement;
    logic        ack_error;
  } result_t;

endpackage

@@ src/i2csm_front.sv @@
// Front part: classifies incoming ticks and holds them in a two-entry queue.
// Depends on i2csm_pkg.
module i2csm_front
  import i2csm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  tx_byte,
  input  logic [7:0]  tx_second_byte,
  input  logic        ack_after_read,
  input  logic        sda_sample,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      new_item;

  always_comb begin
    new_item.start_req      = (cmd >= CMD_START) && (cmd <= CMD_SENSOR_READ);
    new_item.cmd            = cmd;
    new_item.tx_byte        = tx_byte;
    new_item.tx_second_byte = tx_second_byte;
    new_item.ack_after_read = ack_after_read;
    new_item.sda_sample     = sda_sample;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ src/i2csm_engine.sv @@
// Back part: the bus engine that runs one tick per queued request and holds
// the result in an output register. Depends on i2csm_pkg and the defines.
`include "i2c_sensor_bus_master_top_defines.svh"
module i2csm_engine
  import i2csm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tc;
    logic [3:0]  bi;
    logic [2:0]  byi;
    logic [7:0]  sb;
    logic [31:0] av;
    logic [7:0]  wc;
    logic        ef;
    logic [2:0]  op;
    logic [3:0]  ss;
    logic [7:0]  f1;
    logic [7:0]  f2;
    logic        al;
    logic [7:0]  rx;
    logic        lscl;
    logic        lsda;
    logic        ldrv;
  } st_t;

  st_t     st;
  st_t     st_next;
  result_t res_next;

  function automatic st_t reset_state();
    st_t s;
    s = '0;
    s.phase = PH_IDLE;
    s.lscl = 1'b1;
    s.lsda = 1'b1;
    s.ldrv = 1'b1;
    return s;
  endfunction

  function automatic elem_t element_of(input logic [2:0] op, input logic [3:0] s);
    elem_t e;
    e = EL_END;
    if (s <= SEQ_ERR_STOP) begin
      case (op)
        CMD_START: e = (s == 4'd0) ? EL_START : EL_END;
        CMD_STOP: e = (s == 4'd0) ? EL_STOP : EL_END;
        CMD_WRITE: e = (s == 4'd0) ? EL_WRITE : ((s == 4'd1) ? EL_ACK : EL_END);
        CMD_READ: e = (s == 4'd0) ? EL_READ : EL_END;
        CMD_SENSOR_CMD: begin
          if (s == 4'd0) e = EL_START;
          else if (s == 4'd1 || s == 4'd3 || s == 4'd5) e = EL_WRITE;
          else if (s == 4'd2 || s == 4'd4 || s == 4'd6) e = EL_ACK;
          else if (s == 4'd7) e = EL_STOP;
          else e = EL_END;
        end
        CMD_SENSOR_READ: begin
          if (s == 4'd0) e = EL_START;
          else if (s == 4'd1) e = EL_WRITE;
          else if (s == 4'd2) e = EL_ACK;
          else if (s < 4'(3 + READ_BYTES)) e = EL_READ;
          else if (s == 4'(3 + READ_BYTES)) e = EL_STOP;
          else e = EL_END;
        end
        default: e = EL_END;
      endcase
    end
    return e;
  endfunction

  function automatic st_t begin_el(input st_t s_in, input logic [6:0] addr,
                                   output logic fin);
    st_t s;
    s = s_in;
    fin = 1'b0;
    s.tc = '0;
    s.bi = '0;
    case (element_of(s.op, s.ss))
      EL_START: s.phase = PH_ST_A;
      EL_WRITE: begin
        if (s.op == CMD_SENSOR_CMD) begin
          if (s.ss == 4'd1) s.sb = {addr, 1'b0};
          else if (s.ss == 4'd3) s.sb = s.f1;
          else s.sb = s.f2;
        end else if (s.op == CMD_SENSOR_READ) begin
          s.sb = {addr, 1'b1};
        end else begin
          s.sb = s.f1;
        end
        s.phase = PH_WB_SET;
      end
      EL_ACK: begin
        s.wc = '0;
        s.phase = PH_AK_LOW;
      end
      EL_READ: begin
        s.sb = '0;
        s.phase = PH_RB_LOW;
      end
      EL_STOP: s.phase = PH_SP_A;
      default: begin
        s.phase = PH_IDLE;
        fin = 1'b1;
      end
    endcase
    return s;
  endfunction

  function automatic logic read_ack(input st_t s);
    if (s.op == CMD_SENSOR_READ) begin
      return ({1'b0, s.byi} + 4'd1) < 4'(READ_BYTES);
    end
    return s.al;
  endfunction

  always_comb begin
    st_t         s;
    logic        fin;
    logic        busy;
    logic        done;
    logic        scl;
    logic        sda;
    logic        drv;
    logic [16:0] tcn;
    s    = st;
    fin  = 1'b0;
    busy = 1'b0;
    done = 1'b0;
    scl  = st.lscl;
    sda  = st.lsda;
    drv  = st.ldrv;
    tcn  = '0;
    if (s.phase == PH_IDLE && q_item.start_req) begin
      s.op  = q_item.cmd;
      s.f1  = q_item.tx_byte;
      s.f2  = q_item.tx_second_byte;
      s.al  = q_item.ack_after_read;
      s.ef  = 1'b0;
      s.ss  = '0;
      s.byi = '0;
      if (q_item.cmd == CMD_SENSOR_READ) begin
        s.av = '0;
      end
      s = begin_el(s, cfg.device_address, fin);
    end
    if (s.phase != PH_IDLE) begin
      busy = 1'b1;
      drv  = 1'b1;
      case (s.phase)
        PH_ST_A: begin scl = 1'b1; sda = 1'b1; end
        PH_ST_B: begin scl = 1'b1; sda = 1'b0; end
        PH_SP_A: begin scl = 1'b0; sda = 1'b0; end
        PH_SP_B: begin scl = 1'b1; sda = 1'b1; end
        PH_WB_SET, PH_WB_LOW: begin scl = 1'b0; sda = s.sb[7]; end
        PH_WB_HIGH: begin scl = 1'b1; sda = s.sb[7]; end
        PH_WB_TAIL: begin scl = 1'b0; sda = s.lsda; end
        PH_AK_LOW, PH_RB_LOW: begin scl = 1'b0; sda = 1'b1; drv = 1'b0; end
        PH_AK_POLL, PH_RB_HIGH: begin scl = 1'b1; sda = 1'b1; drv = 1'b0; end
        PH_RA_LOW: begin scl = 1'b0; sda = ~read_ack(s); end
        PH_RA_HIGH: begin scl = 1'b1; sda = ~read_ack(s); end
        default: begin scl = s.lscl; sda = s.lsda; drv = s.ldrv; end
      endcase
      s.lscl = scl;
      s.lsda = sda;
      s.ldrv = drv;
      if (s.phase == PH_AK_POLL) begin
        if (!q_item.sda_sample) begin
          s.lscl = 1'b0;
          s.ss = s.ss + 4'd1;
          s = begin_el(s, cfg.device_address, done);
        end else if (s.wc >= cfg.ack_timeout_limit) begin
          s.ef = 1'b1;
          s.ss = SEQ_ERR_STOP;
          s.tc = '0;
          s.phase = PH_SP_A;
        end else begin
          s.wc = s.wc + 8'd1;
        end
      end else begin
        if (s.phase == PH_RB_HIGH && s.tc == 16'd0) begin
          s.sb = {s.sb[6:0], q_item.sda_sample};
        end
        tcn = {1'b0, s.tc} + 17'd1;
        if (tcn < {1'b0, cfg.half_period_ticks}) begin
          s.tc = tcn[15:0];
        end else begin
          s.tc = '0;
          case (s.phase)
            PH_ST_A: s.phase = PH_ST_B;
            PH_ST_B: begin
              s.lscl = 1'b0;
              s.ss = s.ss + 4'd1;
              s = begin_el(s, cfg.device_address, done);
            end
            PH_SP_A: s.phase = PH_SP_B;
            PH_SP_B, PH_WB_TAIL: begin
              s.ss = s.ss + 4'd1;
              s = begin_el(s, cfg.device_address, done);
            end
            PH_WB_SET: s.phase = PH_WB_HIGH;
            PH_WB_HIGH: s.phase = PH_WB_LOW;
            PH_WB_LOW: begin
              s.sb = {s.sb[6:0], 1'b0};
              s.bi = s.bi + 4'd1;
              s.phase = (s.bi >= 4'd8) ? PH_WB_TAIL : PH_WB_SET;
            end
            PH_AK_LOW: s.phase = PH_AK_POLL;
            PH_RB_LOW: s.phase = PH_RB_HIGH;
            PH_RB_HIGH: begin
              s.bi = s.bi + 4'd1;
              s.phase = (s.bi >= 4'd8) ? PH_RA_LOW : PH_RB_LOW;
            end
            PH_RA_LOW: s.phase = PH_RA_HIGH;
            PH_RA_HIGH: begin
              s.rx = s.sb;
              if (s.op == CMD_SENSOR_READ) begin
                if (s.byi != 3'd2) begin
                  s.av = {s.av[23:0], s.sb};
                end
                s.byi = s.byi + 3'd1;
              end
              s.lscl = 1'b0;
              s.ss = s.ss + 4'd1;
              s = begin_el(s, cfg.device_address, done);
            end
            default: begin
              s.phase = PH_IDLE;
              done = 1'b1;
            end
          endcase
        end
      end
    end
    st_next = s;
    res_next.scl_level   = scl;
    res_next.sda_level   = sda;
    res_next.sda_drive   = drv;
    res_next.busy_res    = busy;
    res_next.done_res    = done;
    res_next.rx_byte     = s.rx;
    res_next.measurement = s.av;
    res_next.ack_error   = s.ef;
  end

  assign q_pop = q_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= reset_state();
      res_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        st <= st_next;
      end
      if (q_pop) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= res_next;
    end
  end

  `I2CSM_ASSERT_NOW(a_done_busy, res_valid && res.done_res, res.busy_res)
  `I2CSM_ASSERT_NOW(a_release_high, res_valid && !res.sda_drive, res.sda_level)
  `I2CSM_ASSERT_NEXT(a_timeout_stop, q_pop && !st.ef && st_next.ef, st.phase == PH_SP_A)

endmodule

@@ src/i2c_sensor_bus_master_top.sv @@
// I2C sensor bus master: one input request is one bus timing tick, and each
// tick gives one result with the line levels and status. The block takes a
// request every clock cycle while its two-entry input queue has room; each
// result goes through that queue and then the output register; either side
// may stall on its own. The user must write configuration by cfg_we,
// cfg_index, cfg_data with no request in flight; the block does not check.
// Depends on i2csm_pkg, i2csm_front and i2csm_engine.
module i2c_sensor_bus_master_top
  import i2csm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[2:0], tx_byte[10:3], tx_second_byte[18:11], ack_after_read[19],
  // sda_sample[20], zero fill.
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], measurement[44:13], ack_error[45], zero fill.
  output logic [47:0] m_tdata
);

  cfg_t    cfg;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= 16'd20;
      cfg.ack_timeout_limit <= 8'd250;
      cfg.device_address    <= 7'd88;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        CFG_ACK_TIMEOUT: cfg.ack_timeout_limit <= cfg_data[7:0];
        CFG_DEV_ADDR:    cfg.device_address    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  i2csm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .cmd            (s_tdata[2:0]),
    .tx_byte        (s_tdata[10:3]),
    .tx_second_byte (s_tdata[18:11]),
    .ack_after_read (s_tdata[19]),
    .sda_sample     (s_tdata[20]),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  i2csm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {2'b00, res.ack_error, res.measurement, res.rx_byte, res.done_res,
                    res.busy_res, res.sda_drive, res.sda_level, res.scl_level};

endmodule
